// ----- rtl/core/sipo_pkg.sv -----
// ----------------------------------------------------------------------------
// sipo_pkg
// Shared types, register codes and tilt constants for the serpentine infill
// path ordering block.
// ----------------------------------------------------------------------------
package sipo_pkg;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } t_in;

    typedef struct packed {
        logic               out_valid;
        logic signed [31:0] path_x;
        logic signed [31:0] path_y;
        logic signed [31:0] path_z;
        logic signed [31:0] tilt_x_deg;
        logic signed [31:0] tilt_y_deg;
        logic               is_last;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } t_point;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    typedef struct packed {
        logic signed [31:0] tilt_x;
        logic signed [31:0] tilt_y;
        logic               sat;
    } t_tilt;

    localparam logic [1:0] REG_KEEP_EVERY     = 2'd0;
    localparam logic [1:0] REG_ROW_TOLERANCE  = 2'd1;
    localparam logic [1:0] REG_REVERSE_OUTPUT = 2'd2;

    localparam logic [7:0] KEEP_EVERY_RESET = 8'd3;

    // tilt = num * 18000000 * 2^16 / (den * 314159), rounded half away from zero
    localparam int          TILT_MAG_W = 16;
    localparam int          TILT_AN_W  = 40;
    localparam int          TILT_AD_W  = 34;
    localparam int          TILT_SH    = 17;
    localparam int          TILT_NUM_W = TILT_AN_W + TILT_SH + 1;
    localparam int          TILT_DEN_W = TILT_AD_W + 1;
    localparam int          TILT_CNT_W = $clog2(TILT_NUM_W);
    localparam logic [24:0] TILT_NUM_K = 25'd18000000;
    localparam logic [18:0] TILT_DEN_K = 19'd314159;

    function automatic t_cmp point_cmp(t_point a, t_point b, logic yfirst);
        t_cmp               c;
        logic signed [31:0] a1, b1, a2, b2;
        a1 = yfirst ? a.pos_y : a.pos_x;
        b1 = yfirst ? b.pos_y : b.pos_x;
        a2 = yfirst ? a.pos_x : a.pos_y;
        b2 = yfirst ? b.pos_x : b.pos_y;
        c = '0;
        if (a1 != b1) begin
            c.lt = a1 < b1;
        end else if (a2 != b2) begin
            c.lt = a2 < b2;
        end else if (a.pos_z != b.pos_z) begin
            c.lt = a.pos_z < b.pos_z;
        end else if (a.norm_x != b.norm_x) begin
            c.lt = a.norm_x < b.norm_x;
        end else if (a.norm_y != b.norm_y) begin
            c.lt = a.norm_y < b.norm_y;
        end else if (a.norm_z != b.norm_z) begin
            c.lt = a.norm_z < b.norm_z;
        end else begin
            c.eq = 1'b1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/serpentine_infill_path_order.sv -----
// ----------------------------------------------------------------------------
// serpentine_infill_path_order
// Collects surface points and reads them back as a thinned serpentine path.
// ----------------------------------------------------------------------------
// A load word (mode 0) stores one point, or is not stored once the store is
// full. The first fetch word (mode 1) after any load builds the path in place
// in the order memory: an insertion sort of all points by y, a row scan and
// per-row sort by x, row reversals, and a thinning pass. Each fetch then
// reads one path point and runs the bit-serial divider that computes the two
// tilt angles, one after the other. One word is in work at a time; a finished
// result waits in the output register while the next word is taken.
module serpentine_infill_path_order #(
    parameter int MAX_POINTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sipo_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sipo_pkg::t_out   o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int OW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(MAX_POINTS + 2);

    typedef enum logic [5:0] {
        S_IDLE, S_INIT,
        S_SI, S_SI1, S_SI2, S_SJ, S_SJ1, S_SJ2,
        S_RB, S_RB1, S_RB2, S_RN, S_RN1, S_RN2,
        S_DIR, S_DIR1, S_DIR2,
        S_RV, S_RV1, S_RV2, S_RV3,
        S_HD, S_HD1, S_HD2, S_HD3,
        S_TH0, S_TH, S_TH1, S_TH2, S_TH3, S_TL, S_TL1,
        S_F0, S_F1, S_F2, S_F3, S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt, r_ec, n_ec, r_rp, n_rp;
    logic             r_ready, n_ready;
    logic [CW-1:0]    r_k, n_k, r_i, n_i, r_j, n_j, r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]    r_start, n_start, r_end, n_end, r_a, n_a, r_b, n_b;
    logic [CW-1:0]    r_e, n_e;
    logic [IW-1:0]    r_t, n_t, r_u, n_u;
    sipo_pkg::t_point r_trec, n_trec, r_orec, n_orec;
    logic             r_yfirst, n_yfirst, r_row_any, n_row_any, r_row_odd, n_row_odd;
    logic             r_skip, n_skip;
    logic [31:0]      r_prevx, n_prevx, r_prevy, n_prevy;
    logic [IW:0]      r_va, n_va;
    logic [7:0]       r_tc, n_tc;
    sipo_pkg::t_out   r_res, n_res, r_od, n_od;
    logic             r_ov, n_ov;
    logic [7:0]       r_keep_every;
    logic [15:0]      r_row_tol;
    logic             r_rev;

    logic             pt_we;
    logic [IW-1:0]    pt_waddr, pt_raddr;
    sipo_pkg::t_point pt_wdata, pt_rdata;
    logic             ord_we;
    logic [OW-1:0]    ord_waddr, ord_raddr;
    logic [IW:0]      ord_wdata, ord_rdata;
    logic [IW-1:0]    ord_id;
    logic             ord_head;

    logic             tilt_start, tilt_done;
    sipo_pkg::t_tilt  tilt;

    logic             in_acc, cfg_wr, goes_first, yfar, desc, tc_hit;
    sipo_pkg::t_cmp   cmp;
    logic [32:0]      ydiff, yabs;
    logic [7:0]       ke;
    logic [8:0]       tc_inc;
    logic [CW-1:0]    cnt_m1, fa;

    assign ord_id   = ord_rdata[IW-1:0];
    assign ord_head = ord_rdata[IW];

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    sipo_pt_ram #(
        .DEPTH (MAX_POINTS),
        .AW    (IW)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    sipo_ord_ram #(
        .DEPTH (MAX_POINTS + 1),
        .AW    (OW),
        .DW    (IW + 1)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    sipo_tilt u_tilt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (tilt_start),
        .i_norm_x (pt_rdata.norm_x),
        .i_norm_y (pt_rdata.norm_y),
        .i_norm_z (pt_rdata.norm_z),
        .o_done   (tilt_done),
        .o_tilt   (tilt)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_every <= sipo_pkg::KEEP_EVERY_RESET;
            r_row_tol    <= '0;
            r_rev        <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                sipo_pkg::REG_KEEP_EVERY:     r_keep_every <= pwdata[7:0];
                sipo_pkg::REG_ROW_TOLERANCE:  r_row_tol    <= pwdata[15:0];
                sipo_pkg::REG_REVERSE_OUTPUT: r_rev        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sipo_pkg::REG_KEEP_EVERY:     prdata = {24'd0, r_keep_every};
            sipo_pkg::REG_ROW_TOLERANCE:  prdata = {16'd0, r_row_tol};
            sipo_pkg::REG_REVERSE_OUTPUT: prdata = {31'd0, r_rev};
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        cmp        = sipo_pkg::point_cmp(r_trec, pt_rdata, r_yfirst);
        goes_first = cmp.lt || (cmp.eq && (r_t < r_u));
        ydiff  = {r_prevy[31], r_prevy} - {pt_rdata.pos_y[31], pt_rdata.pos_y};
        yabs   = ydiff[32] ? (33'd0 - ydiff) : ydiff;
        yfar   = yabs > {17'd0, r_row_tol};
        ke     = (r_keep_every == '0) ? 8'd1 : r_keep_every;
        tc_inc = {1'b0, r_tc} + 9'd1;
        tc_hit = tc_inc >= {1'b0, ke};
        cnt_m1 = r_cnt - CW'(1);
        fa     = r_rev ? (r_ec - CW'(1) - r_rp) : r_rp;
        desc   = 1'b0;

        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ec      = r_ec;
        n_rp      = r_rp;
        n_ready   = r_ready;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_start   = r_start;
        n_end     = r_end;
        n_a       = r_a;
        n_b       = r_b;
        n_e       = r_e;
        n_t       = r_t;
        n_u       = r_u;
        n_trec    = r_trec;
        n_orec    = r_orec;
        n_yfirst  = r_yfirst;
        n_row_any = r_row_any;
        n_row_odd = r_row_odd;
        n_skip    = r_skip;
        n_prevx   = r_prevx;
        n_prevy   = r_prevy;
        n_va      = r_va;
        n_tc      = r_tc;
        n_res     = r_res;
        n_od      = r_od;
        n_ov      = r_ov && i_out_stall;

        pt_we      = 1'b0;
        pt_waddr   = r_cnt[IW-1:0];
        pt_wdata   = '{pos_x: i_in_data.pos_x, pos_y: i_in_data.pos_y,
                       pos_z: i_in_data.pos_z, norm_x: i_in_data.norm_x,
                       norm_y: i_in_data.norm_y, norm_z: i_in_data.norm_z};
        pt_raddr   = ord_id;
        ord_we     = 1'b0;
        ord_waddr  = r_k[OW-1:0];
        ord_wdata  = '0;
        ord_raddr  = r_k[OW-1:0];
        tilt_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_in_data.mode) begin
                        if (r_cnt < CW'(MAX_POINTS)) begin
                            pt_we = 1'b1;
                            n_cnt = r_cnt + CW'(1);
                        end
                        n_ready = 1'b0;
                        n_rp    = '0;
                    end else if (r_ready) begin
                        n_state = S_F0;
                    end else if (r_cnt == '0) begin
                        n_ec    = '0;
                        n_rp    = '0;
                        n_ready = 1'b1;
                        n_state = S_F0;
                    end else begin
                        n_k     = '0;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                ord_we    = 1'b1;
                ord_waddr = r_k[OW-1:0];
                ord_wdata = {1'b0, r_k[IW-1:0]};
                if (r_k == cnt_m1) begin
                    n_lo      = '0;
                    n_hi      = cnt_m1;
                    n_i       = CW'(1);
                    n_yfirst  = 1'b1;
                    n_start   = '0;
                    n_row_any = 1'b0;
                    n_row_odd = 1'b0;
                    n_state   = S_SI;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            // Insertion sort of [lo, hi]
            S_SI: begin
                ord_raddr = r_i[OW-1:0];
                if (r_i > r_hi) begin
                    n_state = r_yfirst ? S_RB : S_DIR;
                end else begin
                    n_state = S_SI1;
                end
            end
            S_SI1: begin
                n_t     = ord_id;
                n_j     = r_i;
                n_state = S_SI2;
            end
            S_SI2: begin
                n_trec  = pt_rdata;
                n_state = S_SJ;
            end
            S_SJ: begin
                ord_raddr = OW'(r_j - CW'(1));
                if (r_j == r_lo) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_j[OW-1:0];
                    ord_wdata = {1'b0, r_t};
                    n_i       = r_i + CW'(1);
                    n_state   = S_SI;
                end else begin
                    n_state = S_SJ1;
                end
            end
            S_SJ1: begin
                n_u     = ord_id;
                n_state = S_SJ2;
            end
            S_SJ2: begin
                ord_we    = 1'b1;
                ord_waddr = r_j[OW-1:0];
                if (goes_first) begin
                    ord_wdata = {1'b0, r_u};
                    n_j       = r_j - CW'(1);
                    n_state   = S_SJ;
                end else begin
                    ord_wdata = {1'b0, r_t};
                    n_i       = r_i + CW'(1);
                    n_state   = S_SI;
                end
            end
            // Row scan over y-sorted order
            S_RB: begin
                ord_raddr = r_start[OW-1:0];
                n_state   = S_RB1;
            end
            S_RB1: begin
                n_state = S_RB2;
            end
            S_RB2: begin
                n_prevy = pt_rdata.pos_y;
                n_end   = r_start;
                n_state = S_RN;
            end
            S_RN: begin
                ord_raddr = OW'(r_end + CW'(1));
                if (r_end == cnt_m1) begin
                    n_lo     = r_start;
                    n_hi     = r_end;
                    n_i      = r_start + CW'(1);
                    n_yfirst = 1'b0;
                    n_state  = S_SI;
                end else begin
                    n_state = S_RN1;
                end
            end
            S_RN1: begin
                n_state = S_RN2;
            end
            S_RN2: begin
                if (yfar) begin
                    n_lo     = r_start;
                    n_hi     = r_end;
                    n_i      = r_start + CW'(1);
                    n_yfirst = 1'b0;
                    n_state  = S_SI;
                end else begin
                    n_end   = r_end + CW'(1);
                    n_prevy = pt_rdata.pos_y;
                    n_state = S_RN;
                end
            end
            // Row direction
            S_DIR: begin
                ord_raddr = r_start[OW-1:0];
                if (r_end == cnt_m1 && r_row_any) begin
                    n_state = S_DIR1;
                end else begin
                    desc    = !r_row_odd;
                    n_a     = r_start;
                    n_b     = r_end;
                    n_state = desc ? S_RV : S_HD;
                end
            end
            S_DIR1: begin
                n_state = S_DIR2;
            end
            S_DIR2: begin
                desc    = r_prevx != pt_rdata.pos_x;
                n_a     = r_start;
                n_b     = r_end;
                n_state = desc ? S_RV : S_HD;
            end
            S_RV: begin
                ord_raddr = r_a[OW-1:0];
                n_state   = (r_a < r_b) ? S_RV1 : S_HD;
            end
            S_RV1: begin
                n_va      = ord_rdata;
                ord_raddr = r_b[OW-1:0];
                n_state   = S_RV2;
            end
            S_RV2: begin
                ord_we    = 1'b1;
                ord_waddr = r_a[OW-1:0];
                ord_wdata = ord_rdata;
                n_state   = S_RV3;
            end
            S_RV3: begin
                ord_we    = 1'b1;
                ord_waddr = r_b[OW-1:0];
                ord_wdata = r_va;
                n_a       = r_a + CW'(1);
                n_b       = r_b - CW'(1);
                n_state   = S_RV;
            end
            // Mark row head, note the row's last x
            S_HD: begin
                ord_raddr = r_start[OW-1:0];
                n_state   = S_HD1;
            end
            S_HD1: begin
                ord_we    = 1'b1;
                ord_waddr = r_start[OW-1:0];
                ord_wdata = {1'b1, ord_id};
                ord_raddr = r_end[OW-1:0];
                n_state   = S_HD2;
            end
            S_HD2: begin
                n_state = S_HD3;
            end
            S_HD3: begin
                n_prevx   = pt_rdata.pos_x;
                n_row_any = 1'b1;
                n_row_odd = !r_row_odd;
                if (r_end == cnt_m1) begin
                    n_state = S_TH0;
                end else begin
                    n_start = r_end + CW'(1);
                    n_state = S_RB;
                end
            end
            // Thinning, written back in place
            S_TH0: begin
                n_e    = CW'(1);
                n_k    = CW'(1);
                n_skip = 1'b0;
                n_tc   = '0;
                if (r_cnt == CW'(1)) begin
                    n_ec    = CW'(1);
                    n_rp    = '0;
                    n_ready = 1'b1;
                    n_state = S_F0;
                end else begin
                    n_state = S_TH;
                end
            end
            S_TH: begin
                ord_raddr = r_k[OW-1:0];
                if (r_k >= cnt_m1) begin
                    n_state = S_TL;
                end else if (r_skip) begin
                    n_skip = 1'b0;
                    n_k    = r_k + CW'(1);
                end else begin
                    n_state = S_TH1;
                end
            end
            S_TH1: begin
                n_va      = ord_rdata;
                ord_raddr = OW'(r_k + CW'(1));
                n_state   = S_TH2;
            end
            S_TH2: begin
                ord_waddr = r_e[OW-1:0];
                ord_wdata = {1'b0, r_va[IW-1:0]};
                if (!ord_head) begin
                    if (tc_hit) begin
                        ord_we = 1'b1;
                        n_e    = r_e + CW'(1);
                        n_tc   = '0;
                    end else begin
                        n_tc = tc_inc[7:0];
                    end
                    n_k     = r_k + CW'(1);
                    n_state = S_TH;
                end else begin
                    ord_we  = 1'b1;
                    n_e     = r_e + CW'(1);
                    n_va    = ord_rdata;
                    n_state = S_TH3;
                end
            end
            S_TH3: begin
                ord_we    = 1'b1;
                ord_waddr = r_e[OW-1:0];
                ord_wdata = {1'b0, r_va[IW-1:0]};
                n_e       = r_e + CW'(1);
                n_skip    = 1'b1;
                n_k       = r_k + CW'(1);
                n_state   = S_TH;
            end
            S_TL: begin
                ord_raddr = cnt_m1[OW-1:0];
                n_state   = S_TL1;
            end
            S_TL1: begin
                ord_we    = 1'b1;
                ord_waddr = r_e[OW-1:0];
                ord_wdata = {1'b0, ord_id};
                n_ec      = r_e + CW'(1);
                n_rp      = '0;
                n_ready   = 1'b1;
                n_state   = S_F0;
            end
            // Fetch one path point
            S_F0: begin
                ord_raddr = fa[OW-1:0];
                if (r_rp >= r_ec) begin
                    n_res   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_F1;
                end
            end
            S_F1: begin
                n_state = S_F2;
            end
            S_F2: begin
                n_orec     = pt_rdata;
                tilt_start = 1'b1;
                n_state    = S_F3;
            end
            S_F3: begin
                if (tilt_done) begin
                    n_res.out_valid  = 1'b1;
                    n_res.path_x     = r_orec.pos_x;
                    n_res.path_y     = r_orec.pos_y;
                    n_res.path_z     = r_orec.pos_z;
                    n_res.tilt_x_deg = tilt.tilt_x;
                    n_res.tilt_y_deg = tilt.tilt_y;
                    n_res.is_last    = (r_rp + CW'(1)) == r_ec;
                    n_res.saturated  = tilt.sat;
                    n_rp             = r_rp + CW'(1);
                    n_state          = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_od    = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ec    <= '0;
            r_rp    <= '0;
            r_ready <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ec    <= n_ec;
            r_rp    <= n_rp;
            r_ready <= n_ready;
            r_ov    <= n_ov;
        end
        r_k       <= n_k;
        r_i       <= n_i;
        r_j       <= n_j;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_start   <= n_start;
        r_end     <= n_end;
        r_a       <= n_a;
        r_b       <= n_b;
        r_e       <= n_e;
        r_t       <= n_t;
        r_u       <= n_u;
        r_trec    <= n_trec;
        r_orec    <= n_orec;
        r_yfirst  <= n_yfirst;
        r_row_any <= n_row_any;
        r_row_odd <= n_row_odd;
        r_skip    <= n_skip;
        r_prevx   <= n_prevx;
        r_prevy   <= n_prevy;
        r_va      <= n_va;
        r_tc      <= n_tc;
        r_res     <= n_res;
        r_od      <= n_od;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    a_rp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_rp <= r_ec))
        else $error("read pointer past path end");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count past store depth");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_data.mode) |=> !r_ready)
        else $error("path still marked ready after a load");

    a_ec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> ({1'b0, r_ec} <= ({1'b0, r_cnt} + 1'b1)))
        else $error("path longer than point count plus one");

endmodule

// ----- rtl/core/sipo_pt_ram.sv -----
// ----------------------------------------------------------------------------
// sipo_pt_ram
// Point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sipo_pt_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  sipo_pkg::t_point i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output sipo_pkg::t_point o_rdata
);

    sipo_pkg::t_point r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/sipo_ord_ram.sv -----
// ----------------------------------------------------------------------------
// sipo_ord_ram
// Order store: sorted point indexes with row-head marks, later the path list.
// ----------------------------------------------------------------------------
module sipo_ord_ram #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/sipo_tilt.sv -----
// ----------------------------------------------------------------------------
// sipo_tilt
// Both tilt angles of one normal through a shared restoring divider,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sipo_tilt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_norm_x,
    input  logic signed [15:0] i_norm_y,
    input  logic signed [15:0] i_norm_z,
    output logic               o_done,
    output sipo_pkg::t_tilt    o_tilt
);

    localparam int MW = sipo_pkg::TILT_MAG_W;
    localparam int NW = sipo_pkg::TILT_NUM_W;
    localparam int DW = sipo_pkg::TILT_DEN_W;
    localparam int AW = sipo_pkg::TILT_AN_W;
    localparam int BW = sipo_pkg::TILT_AD_W;
    localparam int KW = sipo_pkg::TILT_CNT_W;

    typedef enum logic [2:0] {T_IDLE, T_MUL, T_LOAD, T_DIV, T_FIN} t_tstate;

    t_tstate            r_state, n_state;
    logic               r_phase, n_phase;
    logic signed [15:0] r_nx, r_ny, r_nz, n_nx, n_ny, n_nz;
    logic [AW-1:0]      r_an, n_an;
    logic [BW-1:0]      r_ad, n_ad;
    logic [NW-1:0]      r_num, n_num, r_q, n_q;
    logic [DW-1:0]      r_den, n_den, r_rem, n_rem;
    logic [KW-1:0]      r_cnt, n_cnt;
    logic               r_done, n_done;
    sipo_pkg::t_tilt    r_tilt, n_tilt;

    logic [MW-1:0]      num_mag, den_mag;
    logic               num_neg, neg;
    logic [DW:0]        trial;
    logic [31:0]        val;
    logic               sat;

    always_comb begin
        num_mag = r_phase ? (r_nx[15] ? MW'(-r_nx) : MW'(r_nx))
                          : (r_ny[15] ? MW'(-r_ny) : MW'(r_ny));
        num_neg = r_phase ? r_nx[15] : (r_ny != '0 && !r_ny[15]);
        den_mag = r_nz[15] ? MW'(-r_nz) : MW'(r_nz);
        neg     = num_neg != r_nz[15];
        trial   = {r_rem, r_num[NW-1]};

        sat = 1'b0;
        if (r_nz == '0) begin
            sat = 1'b1;
            if (num_mag == '0) begin
                val = '0;
            end else if (num_neg) begin
                val = 32'h8000_0000;
            end else begin
                val = 32'h7FFF_FFFF;
            end
        end else if (neg) begin
            if (r_q > NW'(33'h0_8000_0000)) begin
                sat = 1'b1;
                val = 32'h8000_0000;
            end else begin
                val = 32'd0 - r_q[31:0];
            end
        end else begin
            if (r_q > NW'(32'h7FFF_FFFF)) begin
                sat = 1'b1;
                val = 32'h7FFF_FFFF;
            end else begin
                val = r_q[31:0];
            end
        end

        n_state = r_state;
        n_phase = r_phase;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_nz    = r_nz;
        n_an    = r_an;
        n_ad    = r_ad;
        n_num   = r_num;
        n_q     = r_q;
        n_den   = r_den;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_tilt  = r_tilt;

        case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    n_nx       = i_norm_x;
                    n_ny       = i_norm_y;
                    n_nz       = i_norm_z;
                    n_phase    = 1'b0;
                    n_tilt.sat = 1'b0;
                    n_state    = T_MUL;
                end
            end
            T_MUL: begin
                n_an    = AW'(num_mag * sipo_pkg::TILT_NUM_K);
                n_ad    = BW'(den_mag * sipo_pkg::TILT_DEN_K);
                n_state = T_LOAD;
            end
            T_LOAD: begin
                n_num   = NW'({r_an, {sipo_pkg::TILT_SH{1'b0}}}) + NW'(r_ad);
                n_den   = {r_ad, 1'b0};
                n_rem   = '0;
                n_q     = '0;
                n_cnt   = '0;
                n_state = T_DIV;
            end
            T_DIV: begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = DW'(trial - {1'b0, r_den});
                    n_q   = {r_q[NW-2:0], 1'b1};
                end else begin
                    n_rem = trial[DW-1:0];
                    n_q   = {r_q[NW-2:0], 1'b0};
                end
                n_num = {r_num[NW-2:0], 1'b0};
                n_cnt = r_cnt + KW'(1);
                if (r_cnt == KW'(NW - 1)) begin
                    n_state = T_FIN;
                end
            end
            T_FIN: begin
                n_tilt.sat = r_tilt.sat | sat;
                if (!r_phase) begin
                    n_tilt.tilt_x = val;
                    n_phase       = 1'b1;
                    n_state       = T_MUL;
                end else begin
                    n_tilt.tilt_y = val;
                    n_done        = 1'b1;
                    n_state       = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_phase <= n_phase;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_nz    <= n_nz;
        r_an    <= n_an;
        r_ad    <= n_ad;
        r_num   <= n_num;
        r_q     <= n_q;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_tilt  <= n_tilt;
    end

    assign o_done = r_done;
    assign o_tilt = r_tilt;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Serpentine path ordering testbench
// Loads points and fetches path points through the valid/stall word channels,
// with register writes over the APB port between phases. An in-bench
// predictor sorts, splits rows, orders each row and thins the path, then works
// out the tilt angles. Each fetched result is checked against the oldest
// prediction. Inputs idle and outputs stall at random, save in one test.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP      = 1024;
    localparam int SETTLE   = 300;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    sipo_pkg::t_in   i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    sipo_pkg::t_out  o_out_data;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [3:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    serpentine_infill_path_order i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // point store and path state of the predictor
    logic signed [31:0] pt_x [CAP];
    logic signed [31:0] pt_y [CAP];
    logic signed [31:0] pt_z [CAP];
    logic signed [15:0] pt_nx [CAP];
    logic signed [15:0] pt_ny [CAP];
    logic signed [15:0] pt_nz [CAP];
    int    by_y [CAP];
    int    route [CAP];
    bit    row_start [CAP];
    int    keep_list [CAP+1];
    int    stored_cnt, keep_cnt, read_pos;
    bit    route_built;
    logic [7:0]  cfg_keep;
    logic [15:0] cfg_tol;
    logic        cfg_rev;

    sipo_pkg::t_out pending_points [$];
    int    mismatches, checked, loads_sent, fetches_sent, empty_seen;
    bit    idle_on = 1'b1;
    longint y_cursor;

    function automatic longint key_of(int p, int f);
        case (f)
            0: return pt_x[p];
            1: return pt_y[p];
            2: return pt_z[p];
            3: return pt_nx[p];
            4: return pt_ny[p];
            default: return pt_nz[p];
        endcase
    endfunction

    function automatic bit orders_first(int a, int b, bit yfirst);
        longint va, vb;
        int     f;
        for (int i = 0; i < 6; i++) begin
            f = (i == 0) ? (yfirst ? 1 : 0) : (i == 1) ? (yfirst ? 0 : 1) : i;
            va = key_of(a, f);
            vb = key_of(b, f);
            if (va != vb) return va < vb;
        end
        return a < b;
    endfunction

    task automatic sort_span(ref int v [CAP], input int lo, input int hi, input bit yfirst);
        int t, j;
        for (int i = lo + 1; i <= hi; i++) begin
            t = v[i];
            j = i;
            while (j > lo && orders_first(t, v[j-1], yfirst)) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
    endtask

    task automatic build_serpentine();
        int     n, start, stop, row, cnt, ke, t, a, b;
        bit     desc, skip;
        longint d;
        n = stored_cnt;
        keep_cnt = 0;
        row = 0;
        cnt = 0;
        skip = 1'b0;
        start = 0;
        if (n == 0) return;
        for (int i = 0; i < n; i++) by_y[i] = i;
        sort_span(by_y, 0, n - 1, 1'b1);
        while (start < n) begin
            stop = start;
            while (stop + 1 < n) begin
                d = key_of(by_y[stop], 1) - key_of(by_y[stop+1], 1);
                if (d < 0) d = -d;
                if (d > longint'(cfg_tol)) break;
                stop++;
            end
            for (int i = start; i <= stop; i++) route[i] = by_y[i];
            sort_span(route, start, stop, 1'b0);
            if (stop == n - 1 && row > 0)
                desc = key_of(route[start-1], 0) != key_of(route[start], 0);
            else
                desc = (row % 2) == 0;
            if (desc) begin
                a = start;
                b = stop;
                while (a < b) begin
                    t = route[a]; route[a] = route[b]; route[b] = t;
                    a++; b--;
                end
            end
            for (int i = start; i <= stop; i++) row_start[i] = (i == start);
            row++;
            start = stop + 1;
        end
        keep_list[keep_cnt++] = route[0];
        if (n == 1) return;
        ke = (cfg_keep == 0) ? 1 : cfg_keep;
        for (int i = 1; i + 1 < n; i++) begin
            if (skip) begin
                skip = 1'b0;
                continue;
            end
            if (!row_start[i+1]) begin
                cnt++;
                if (cnt >= ke) begin
                    keep_list[keep_cnt++] = route[i];
                    cnt = 0;
                end
            end else begin
                keep_list[keep_cnt++] = route[i];
                keep_list[keep_cnt++] = route[i+1];
                skip = 1'b1;
            end
        end
        keep_list[keep_cnt++] = route[n-1];
    endtask

    function automatic logic [31:0] tilt_deg(longint num, longint den, inout bit sat);
        longint          n, d;
        longint unsigned an, ad, q;
        bit              neg;
        n = num * 64'sd1179648000000;
        d = den * 64'sd314159;
        if (d == 0) begin
            sat = 1'b1;
            return (n > 0) ? 32'h7FFF_FFFF : (n < 0) ? 32'h8000_0000 : 32'h0;
        end
        neg = (n < 0) != (d < 0);
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        if (!neg && q > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            q = 64'h7FFF_FFFF;
        end
        if (neg && q > 64'h8000_0000) begin
            sat = 1'b1;
            q = 64'h8000_0000;
        end
        return neg ? (32'h0 - q[31:0]) : q[31:0];
    endfunction

    task automatic next_path_point(output sipo_pkg::t_out r);
        int p;
        bit sat;
        sat = 1'b0;
        r = '0;
        if (!route_built) begin
            build_serpentine();
            route_built = 1'b1;
            read_pos = 0;
        end
        if (read_pos >= keep_cnt) return;
        p = cfg_rev ? keep_list[keep_cnt - 1 - read_pos] : keep_list[read_pos];
        read_pos++;
        r.out_valid  = 1'b1;
        r.path_x     = pt_x[p];
        r.path_y     = pt_y[p];
        r.path_z     = pt_z[p];
        r.tilt_x_deg = tilt_deg(-longint'(pt_ny[p]), pt_nz[p], sat);
        r.tilt_y_deg = tilt_deg(longint'(pt_nx[p]), pt_nz[p], sat);
        r.is_last    = (read_pos == keep_cnt);
        r.saturated  = sat;
    endtask

    task automatic send_word(input sipo_pkg::t_in w);
        if (idle_on) begin
            while ($urandom_range(99) < 27) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
    endtask

    task automatic load_point(input logic [31:0] x, y, z, input logic [15:0] nx, ny, nz);
        sipo_pkg::t_in w;
        w = '{mode: 1'b0, pos_x: x, pos_y: y, pos_z: z, norm_x: nx, norm_y: ny, norm_z: nz};
        if (stored_cnt < CAP) begin
            pt_x[stored_cnt] = x;
            pt_y[stored_cnt] = y;
            pt_z[stored_cnt] = z;
            pt_nx[stored_cnt] = nx;
            pt_ny[stored_cnt] = ny;
            pt_nz[stored_cnt] = nz;
            stored_cnt++;
        end
        route_built = 1'b0;
        read_pos = 0;
        loads_sent++;
        send_word(w);
    endtask

    task automatic fetch_point();
        sipo_pkg::t_in  w;
        sipo_pkg::t_out r;
        logic [223:0]   noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = noise[$bits(sipo_pkg::t_in)-1:0];
        w.mode = 1'b1;
        next_path_point(r);
        pending_points.push_back(r);
        fetches_sent++;
        send_word(w);
    endtask

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(9))
            0: return 16'h0;
            1: return 16'($signed($urandom_range(32)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    // y mostly climbs so the insertion sort in the block stays cheap
    function automatic logic [31:0] rand_y();
        longint y;
        case ($urandom_range(19))
            0, 1: y = y_cursor;
            2: y = y_cursor - $urandom_range(200000);
            3, 4, 5, 6, 7, 8: y = y_cursor + $urandom_range(70000);
            default: y = y_cursor + $urandom_range(2500000, 70000);
        endcase
        if (y > 64'sh7FFF_FFFE) y = 64'sh7FFF_FFFE;
        if (y < -64'sh8000_0000) y = -64'sh8000_0000;
        if (y > y_cursor) y_cursor = y;
        return y[31:0];
    endfunction

    task automatic load_random();
        load_point($urandom, rand_y(), $urandom, rand_normal(), rand_normal(), rand_normal());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sipo_pkg::REG_KEEP_EVERY:    cfg_keep = val[7:0];
            sipo_pkg::REG_ROW_TOLERANCE: cfg_tol = val[15:0];
            default:                     cfg_rev = val[0];
        endcase
    endtask

    task automatic setup(input logic [7:0] ke, input logic [15:0] tol, input logic rev);
        write_reg(sipo_pkg::REG_KEEP_EVERY, {24'h0, ke});
        write_reg(sipo_pkg::REG_ROW_TOLERANCE, {16'h0, tol});
        write_reg(sipo_pkg::REG_REVERSE_OUTPUT, {31'h0, rev});
    endtask

    always @(posedge i_clk) begin
        sipo_pkg::t_out want;
        i_out_stall <= idle_on && ($urandom_range(99) < 27);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            checked++;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                want = pending_points.pop_front();
                if (!o_out_data.out_valid) empty_seen++;
                if (o_out_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch %0d: valid %b/%b x %h/%h y %h/%h z %h/%h",
                            checked, want.out_valid, o_out_data.out_valid,
                            want.path_x, o_out_data.path_x, want.path_y,
                            o_out_data.path_y, want.path_z, o_out_data.path_z);
                        $display("  tilt %h,%h/%h,%h last %b/%b sat %b/%b",
                            want.tilt_x_deg, want.tilt_y_deg, o_out_data.tilt_x_deg,
                            o_out_data.tilt_y_deg, want.is_last, o_out_data.is_last,
                            want.saturated, o_out_data.saturated);
                    end
                end
            end
        end
    end

    task automatic test_empty_store();
        fetch_point();
        fetch_point();
    endtask

    task automatic test_single_point();
        y_cursor = -64'sh8000_0000;
        load_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h0);
        fetch_point();
        fetch_point();
    endtask

    task automatic test_extremes();
        load_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        load_point(32'h0, 32'h8000_0000, 32'h0, 16'h0, 16'h0, 16'h0);
        load_point(32'h1234, 32'h8000_0001, 32'h5, 16'hFFF0, 16'h0010, 16'h0);
        load_point(32'h1234, 32'h8000_0001, 32'h5, 16'hFFF0, 16'h0010, 16'h0);
        load_point(32'hFFFF_0000, 32'h8001_0000, 32'h1, 16'h2000, 16'hE000, 16'h4000);
        load_point(32'h0001_0000, 32'h8001_0000, 32'h2, 16'h0001, 16'h0001, 16'h8000);
        load_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        y_cursor = 64'sh8001_0000 - 64'sh1_0000_0000;
        for (int i = 0; i < 5; i++) fetch_point();
        write_reg(sipo_pkg::REG_REVERSE_OUTPUT, 32'h1);
        for (int i = 0; i < 6; i++) fetch_point();
        load_point($urandom, 32'h8001_0000, $urandom, 16'h0100, 16'h0200, 16'h0300);
        for (int i = 0; i < 4; i++) fetch_point();
    endtask

    task automatic test_register_sweep();
        logic [7:0] ke [4] = '{8'd0, 8'd1, 8'd255, 8'd2};
        logic [15:0] tol [4] = '{16'd65535, 16'd0, 16'd40000, 16'd65535};
        for (int k = 0; k < 4; k++) begin
            setup(ke[k], tol[k], k[0]);
            for (int i = 0; i < 4; i++) load_random();
            for (int i = 0; i < 12; i++) fetch_point();
        end
    endtask

    task automatic test_random_batches();
        int nb;
        while (loads_sent + fetches_sent < 800) begin
            setup($urandom_range(6) == 0 ? 8'($urandom) : 8'($urandom_range(5)),
                  $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(70000) % 65536),
                  $urandom_range(1));
            nb = $urandom_range(14, 1);
            for (int i = 0; i < nb; i++) load_random();
            nb = $urandom_range(24, 1);
            for (int i = 0; i < nb; i++) begin
                if ($urandom_range(19) == 0) load_random();
                else fetch_point();
            end
        end
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        setup(8'd1, 16'd65535, 1'b0);
        for (int i = 0; i < 10; i++) load_random();
        for (int i = 0; i < 30; i++) fetch_point();
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_store_full();
        setup(8'd2, 16'd0, 1'b0);
        while (stored_cnt < CAP) load_random();
        load_random();
        load_random();
        for (int i = 0; i < 15; i++) fetch_point();
        write_reg(sipo_pkg::REG_REVERSE_OUTPUT, 32'h1);
        for (int i = 0; i < 15; i++) fetch_point();
    endtask

    initial begin
        stored_cnt = 0; keep_cnt = 0; read_pos = 0; route_built = 1'b0;
        cfg_keep = sipo_pkg::KEEP_EVERY_RESET; cfg_tol = '0; cfg_rev = 1'b0;
        mismatches = 0; checked = 0; loads_sent = 0; fetches_sent = 0; empty_seen = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_store();
        test_single_point();
        test_extremes();
        test_register_sweep();
        test_no_idle();
        test_random_batches();
        test_store_full();
        drain();
        $display("covered %0d loads and %0d fetches, %0d results checked, %0d past path end",
                 loads_sent, fetches_sent, checked, empty_seen);
        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_points.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout with %0d results outstanding", pending_points.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- serpentine_infill_path_order.f -----
rtl/core/sipo_pkg.sv
rtl/core/sipo_pt_ram.sv
rtl/core/sipo_ord_ram.sv
rtl/core/sipo_tilt.sv
rtl/core/serpentine_infill_path_order.sv
sim/testbench.sv
